// ===== design/apa_pkg.sv =====
package apa_pkg;

	localparam int APA_CHANNELS = 256;
	localparam logic [15:0] MIN_PEDS_RESET = 16'd500;
	localparam logic [16:0] LIM_MAX = 17'h1FFFF;
	localparam logic [31:0] SUM_MAX = 32'hFFFFFFFF;
	localparam logic [47:0] SQ_MAX = 48'hFFFFFFFFFFFF;
	localparam logic [15:0] CNT_MAX = 16'hFFFF;
	localparam logic [19:0] PED_MAX = 20'hFFFFF;
	localparam logic [18:0] SIG_MAX = 19'h7FFFF;
	localparam logic [20:0] TH_LOW = 21'd160;
	localparam logic [20:0] TH_HIGH = 21'd800;
	localparam logic [16:0] RETUNE_OFFSET = 17'd100;
	// x/5 as (x*RECIP5)>>18, exact for 16-bit x
	localparam logic [17:0] RECIP5 = 18'd52429;
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [7:0]  channel;
		logic [15:0] adc_value;
		logic [16:0] limit_value;
	} apa_req_t;

	typedef struct packed {
		logic        accepted;
		logic [15:0] sample_count;
		logic [16:0] current_limit;
		logic [19:0] pedestal_q4;
		logic [18:0] sigma_q4;
		logic [20:0] threshold_q4;
	} apa_res_t;

	typedef struct packed {
		logic [16:0] lim;
		logic [31:0] sum;
		logic [47:0] sq;
		logic [15:0] cnt;
	} apa_row_t;

endpackage

// ===== design/adaptive_pedestal_accumulator_core.sv =====
// Pedestal accumulator for up to CHANNELS calorimeter ADC channels.
// Request channel: req is taken at a rising edge with start high and busy
// low. mode load sets the channel's starting limit and clears its sums;
// mode sample offers an ADC value, accumulated when at or below the limit.
// Result channel: done is high for one cycle with result valid; it must be
// taken in that cycle, the receiver cannot stall the block.
// Config channel: cfg_data (min_peds) is written when cfg_valid is high,
// cfg_ready is always high; write it only while busy is low and no result
// is pending.
// Steps: after the edge that takes a request come the channel read, the
// sums and products on the shared 32x32 multiplier, a square root and
// two divisions each after a setup state, all one bit per cycle on one
// shared trial subtractor, and a final state that registers the result.
// The next request can be taken on the edge that ends the done cycle; no
// new request is taken while one is still in progress.
// A channel number at or above CHANNELS gets an all-zero result on the
// cycle after it is taken.
// Reset: min_peds returns to 500, and the channel memory is cleared by a
// sweep over all CHANNELS entries during which busy is high.
module adaptive_pedestal_accumulator_core
	import apa_pkg::*;
#(
	parameter int CHANNELS = APA_CHANNELS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  apa_req_t    req,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output logic        done,
	output apa_res_t    result
);

	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_MSQ, ST_ACC, ST_SS, ST_NSLO, ST_NSHI, ST_VAR,
		ST_SQRT, ST_SDIV, ST_SIGD, ST_PDIV, ST_PEDD, ST_FIN
	} state_t;

	state_t state_q;
	apa_row_t mem [CHANNELS];
	apa_row_t rd_q;
	apa_req_t req_q;
	logic [CW-1:0] idx_q, clr_q;
	logic [15:0] min_q, mind5_q;
	logic [33:0] m5;
	logic acc_q;
	logic [16:0] lim_q;
	logic [31:0] sum_q;
	logic [47:0] sq_q;
	logic [15:0] cnt_q, dvs_q;
	logic [63:0] a_q, b_q;
	logic [71:0] work_q;
	logic [36:0] rem_q;
	logic [35:0] root_q;
	logic [18:0] sig_q;
	logic [5:0] it_q;
	apa_res_t result_q;
	logic done_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;
	logic sqrt_mode;
	logic [38:0] op_a, op_b;
	logic [39:0] diff;
	logic ge;
	logic oor;
	logic [32:0] sum_add;
	logic [48:0] sq_add;
	logic [19:0] ped;
	logic [32:0] nl;
	logic [16:0] lim_fin;
	logic [20:0] t3, th;

	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done = done_q;
	assign result = result_q;
	assign oor = (32'(req.channel) >= 32'(CHANNELS));
	assign m5 = 34'(min_q) * 34'(RECIP5);

	// shared multiplier
	always_comb begin
		case (state_q)
			ST_MSQ: begin
				mul_a = 32'(req_q.adc_value);
				mul_b = 32'(req_q.adc_value);
			end
			ST_SS: begin
				mul_a = sum_q;
				mul_b = sum_q;
			end
			ST_NSLO: begin
				mul_a = 32'(cnt_q);
				mul_b = 32'(sq_q[23:0]);
			end
			ST_NSHI: begin
				mul_a = 32'(cnt_q);
				mul_b = 32'(sq_q[47:24]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign prod = 64'(mul_a) * 64'(mul_b);

	// shared trial subtractor for square root and division
	assign sqrt_mode = (state_q == ST_SQRT);
	assign op_a = sqrt_mode ? {rem_q, work_q[71:70]} : {22'b0, rem_q[15:0], work_q[71]};
	assign op_b = sqrt_mode ? {1'b0, root_q, 2'b01} : {23'b0, dvs_q};
	assign diff = {1'b0, op_a} - {1'b0, op_b};
	assign ge = !diff[39];

	assign sum_add = {1'b0, sum_q} + 33'(req_q.adc_value);
	assign sq_add = {1'b0, sq_q} + 49'(a_q[31:0]);

	// final figures, root_q holds floor(16*sum/n)
	always_comb begin
		ped = (root_q > 36'(PED_MAX)) ? PED_MAX : root_q[19:0];
		nl = {1'b0, root_q[35:4]} + 33'(RETUNE_OFFSET);
		lim_fin = lim_q;
		if (acc_q && (cnt_q == mind5_q)) begin
			lim_fin = (nl > 33'(LIM_MAX)) ? LIM_MAX : nl[16:0];
		end
		t3 = 21'(sig_q) * 21'd3;
		if (t3 < TH_LOW) begin
			t3 = TH_LOW;
		end
		if (t3 > TH_HIGH) begin
			t3 = TH_HIGH;
		end
		th = 21'(ped) + t3;
	end

	// channel memory
	always_ff @(posedge clk) begin
		if (state_q == ST_CLR) begin
			mem[clr_q] <= '0;
		end else if (state_q == ST_FIN) begin
			mem[idx_q] <= '{lim: lim_fin, sum: sum_q, sq: sq_q, cnt: cnt_q};
		end
		if (state_q == ST_IDLE) begin
			rd_q <= mem[CW'(req.channel)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
			min_q <= MIN_PEDS_RESET;
			mind5_q <= 16'd100;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				min_q <= cfg_data;
			end
			mind5_q <= m5[33:18];
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CW'(CHANNELS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						req_q <= req;
						idx_q <= CW'(req.channel);
						if (oor) begin
							result_q <= '0;
							done_q <= 1'b1;
						end else begin
							state_q <= ST_MSQ;
						end
					end
				end
				ST_MSQ: begin
					a_q <= prod;
					acc_q <= (req_q.mode == MODE_SAMPLE) &&
						(17'(req_q.adc_value) <= rd_q.lim);
					lim_q <= rd_q.lim;
					sum_q <= rd_q.sum;
					sq_q <= rd_q.sq;
					cnt_q <= rd_q.cnt;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (req_q.mode == MODE_LOAD) begin
						lim_q <= req_q.limit_value;
						sum_q <= '0;
						sq_q <= '0;
						cnt_q <= '0;
					end else if (acc_q) begin
						sum_q <= sum_add[32] ? SUM_MAX : sum_add[31:0];
						sq_q <= sq_add[48] ? SQ_MAX : sq_add[47:0];
						if (cnt_q != CNT_MAX) begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
					state_q <= ST_SS;
				end
				ST_SS: begin
					b_q <= prod;
					state_q <= ST_NSLO;
				end
				ST_NSLO: begin
					a_q <= prod;
					state_q <= ST_NSHI;
				end
				ST_NSHI: begin
					a_q <= a_q + {prod[39:0], 24'b0};
					state_q <= ST_VAR;
				end
				ST_VAR: begin
					work_q <= (a_q > b_q) ? {a_q - b_q, 8'b0} : '0;
					rem_q <= '0;
					root_q <= '0;
					dvs_q <= (cnt_q == '0) ? 16'd1 : cnt_q;
					it_q <= 6'd35;
					state_q <= ST_SQRT;
				end
				ST_SQRT, ST_SIGD, ST_PEDD: begin
					rem_q <= ge ? diff[36:0] : op_a[36:0];
					root_q <= {root_q[34:0], ge};
					work_q <= sqrt_mode ? {work_q[69:0], 2'b00} : {work_q[70:0], 1'b0};
					it_q <= it_q - 1'b1;
					if (it_q == '0) begin
						case (state_q)
							ST_SQRT: state_q <= ST_SDIV;
							ST_SIGD: state_q <= ST_PDIV;
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_SDIV: begin
					work_q <= {root_q, 36'b0};
					rem_q <= '0;
					root_q <= '0;
					it_q <= 6'd35;
					state_q <= ST_SIGD;
				end
				ST_PDIV: begin
					sig_q <= (root_q > 36'(SIG_MAX)) ? SIG_MAX : root_q[18:0];
					work_q <= {sum_q, 40'b0};
					rem_q <= '0;
					root_q <= '0;
					it_q <= 6'd35;
					state_q <= ST_PEDD;
				end
				ST_FIN: begin
					result_q <= '{accepted: acc_q, sample_count: cnt_q,
						current_limit: lim_fin, pedestal_q4: ped,
						sigma_q4: sig_q, threshold_q4: th};
					done_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
